// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that check their own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Expression must hold on every clock edge out of reset
`define XRCD_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Consequent must hold on the same edge as the antecedent
`define XRCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold on the edge after the antecedent
`define XRCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define XRCD_ASSERT(lbl, expr, msg)
`define XRCD_ASSERT_SAME(lbl, ante, cons, msg)
`define XRCD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/xrcd_pkg.sv -----
// Shared widths, decode codes and control/status types of the cell decoder.
`default_nettype none

package xrcd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;
    localparam int LEFT_W  = 7;
    localparam int LEN_W   = 6;
    localparam int TDATA_W = 48;

    // Decode phase
    localparam logic [1:0] PH_CTRL  = 2'd0;  // expect control byte
    localparam logic [1:0] PH_FIRST = 2'd1;  // expect first byte of a cell
    localparam logic [1:0] PH_NEXT  = 2'd2;  // expect following byte

    // Run modes from the top two bits of a control byte
    localparam logic [1:0] MODE_RAW        = 2'd0;
    localparam logic [1:0] MODE_FIXED_CHAR = 2'd1;
    localparam logic [1:0] MODE_FIXED_ATTR = 2'd2;
    localparam logic [1:0] MODE_REPEAT     = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic take;      // input word accepted this cycle
        logic rep_emit;  // step the repeat run by one cell
    } xrcd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;  // output register empty or being drained
        logic rep_start;  // word on the input closes a repeat header
        logic rep_end;    // this repeat step is the last of the run
    } xrcd_stat_t;

endpackage

`default_nettype wire

// ----- rtl/xrcd_ctrl.sv -----
// Controller: byte intake versus repeat-run emission.
`default_nettype none

module xrcd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire xrcd_pkg::xrcd_stat_t stat,
    output xrcd_pkg::xrcd_cmd_t     cmd
);
    import xrcd_pkg::*;

    localparam logic ST_BYTE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    // Input is open only between runs and while the output slot can take a word
    always_comb begin
        s_tready     = (state_reg == ST_BYTE) && stat.slot_free;
        cmd.take     = s_tready && s_tvalid;
        cmd.rep_emit = (state_reg == ST_RUN) && stat.slot_free;
        state_next   = state_reg;
        case (state_reg)
            ST_BYTE: begin
                if (cmd.take && stat.rep_start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cmd.rep_emit && stat.rep_end) begin
                    state_next = ST_BYTE;
                end
            end
            default: state_next = ST_BYTE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BYTE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/xrcd_datapath.sv -----
// Datapath: decode state, cell counter, total register and output register.
`default_nettype none

module xrcd_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [xrcd_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                          in_frame_start,
    input  wire logic                          cfg_we,
    input  wire logic [xrcd_pkg::COUNT_W-1:0]  cfg_wdata,
    input  wire xrcd_pkg::xrcd_cmd_t           cmd,
    output xrcd_pkg::xrcd_stat_t               stat,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [xrcd_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    output logic [0:0]                         m_tuser
);
    import xrcd_pkg::*;

    logic [1:0]         phase_reg, phase_next;
    logic [1:0]         mode_reg, mode_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [BYTE_W-1:0]  hchar_reg, hchar_next;
    logic [BYTE_W-1:0]  hattr_reg, hattr_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               fin_reg, fin_next;
    logic [COUNT_W-1:0] total_reg;

    logic               ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0]  ochar_reg, ochar_next;
    logic [BYTE_W-1:0]  oattr_reg, oattr_next;
    logic [COUNT_W-1:0] oidx_reg, oidx_next;
    logic               olast_reg, olast_next;
    logic               odone_reg, odone_next;
    logic               load;

    // State as seen by an incoming word (frame start clears it first)
    logic [1:0]         e_phase, e_mode;
    logic [LEFT_W-1:0]  e_left, e_left_dec;
    logic [BYTE_W-1:0]  e_hchar, e_hattr;
    logic [COUNT_W-1:0] e_cnt;
    logic               e_fin, b_can, b_done;
    logic               r_can, r_done;

    always_comb begin
        e_phase    = in_frame_start ? PH_CTRL : phase_reg;
        e_mode     = in_frame_start ? MODE_RAW : mode_reg;
        e_left     = in_frame_start ? '0 : left_reg;
        e_hchar    = in_frame_start ? '0 : hchar_reg;
        e_hattr    = in_frame_start ? '0 : hattr_reg;
        e_cnt      = in_frame_start ? '0 : cnt_reg;
        e_fin      = in_frame_start ? 1'b0 : fin_reg;
        e_left_dec = e_left - LEFT_W'(1);
        b_can      = !e_fin && (e_cnt < total_reg);
        b_done     = (e_cnt == total_reg - COUNT_W'(1));
        r_can      = !fin_reg && (cnt_reg < total_reg);
        r_done     = (cnt_reg == total_reg - COUNT_W'(1));
    end

    // Status to the controller
    always_comb begin
        stat.slot_free = !ovalid_reg || m_tready;
        stat.rep_start = !in_frame_start && !fin_reg && (phase_reg == PH_NEXT)
                         && (mode_reg == MODE_REPEAT);
        stat.rep_end   = !r_can || (left_reg == LEFT_W'(1)) || r_done;
    end

    // Next decode state and output load
    always_comb begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        left_next  = left_reg;
        hchar_next = hchar_reg;
        hattr_next = hattr_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        load       = 1'b0;
        ochar_next = ochar_reg;
        oattr_next = oattr_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        odone_next = odone_reg;

        if (cmd.take) begin
            phase_next = e_phase;
            mode_next  = e_mode;
            left_next  = e_left;
            hchar_next = e_hchar;
            hattr_next = e_hattr;
            cnt_next   = e_cnt;
            fin_next   = e_fin;
            if (!e_fin) begin
                case (e_phase)
                    PH_FIRST: begin
                        if (e_mode == MODE_FIXED_ATTR) begin
                            hattr_next = in_byte;
                        end else begin
                            hchar_next = in_byte;
                        end
                        phase_next = PH_NEXT;
                    end
                    PH_NEXT: begin
                        if (e_mode == MODE_REPEAT) begin
                            // run is played out by the repeat steps
                            hattr_next = in_byte;
                        end else begin
                            load       = b_can;
                            ochar_next = (e_mode == MODE_FIXED_ATTR) ? in_byte : e_hchar;
                            oattr_next = (e_mode == MODE_FIXED_ATTR) ? e_hattr : in_byte;
                            oidx_next  = e_cnt;
                            olast_next = 1'b1;
                            odone_next = b_done;
                            if (b_can) begin
                                cnt_next = e_cnt + COUNT_W'(1);
                                fin_next = b_done;
                            end
                            left_next = e_left_dec;
                            if (e_left_dec == '0) begin
                                phase_next = PH_CTRL;
                            end else if (e_mode == MODE_RAW) begin
                                phase_next = PH_FIRST;
                            end else begin
                                phase_next = PH_NEXT;
                            end
                        end
                    end
                    default: begin
                        mode_next  = in_byte[BYTE_W-1 -: 2];
                        left_next  = {1'b0, in_byte[LEN_W-1:0]} + LEFT_W'(1);
                        phase_next = PH_FIRST;
                    end
                endcase
            end
        end

        // One repeated cell per step
        if (cmd.rep_emit) begin
            if (r_can) begin
                load       = 1'b1;
                ochar_next = hchar_reg;
                oattr_next = hattr_reg;
                oidx_next  = cnt_reg;
                olast_next = stat.rep_end;
                odone_next = r_done;
                cnt_next   = cnt_reg + COUNT_W'(1);
                fin_next   = r_done;
                left_next  = left_reg - LEFT_W'(1);
            end
            if (stat.rep_end) begin
                left_next  = '0;
                phase_next = PH_CTRL;
            end
        end

        ovalid_next = load ? 1'b1 : (m_tready ? 1'b0 : ovalid_reg);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_CTRL;
            mode_reg   <= MODE_RAW;
            left_reg   <= '0;
            hchar_reg  <= '0;
            hattr_reg  <= '0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            total_reg  <= COUNT_W'(1);
            ovalid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            mode_reg   <= mode_next;
            left_reg   <= left_next;
            hchar_reg  <= hchar_next;
            hattr_reg  <= hattr_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we) begin
                total_reg <= cfg_wdata;
            end
        end
    end

    // Output word payload
    always_ff @(posedge aclk) begin
        ochar_reg <= ochar_next;
        oattr_reg <= oattr_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
        odone_reg <= odone_next;
    end

    assign m_tvalid   = ovalid_reg;
    assign m_tdata    = {oidx_reg, oattr_reg, ochar_reg};
    assign m_tlast    = olast_reg;
    assign m_tuser[0] = odone_reg;

endmodule

`default_nettype wire

// ----- rtl/xbin_rle_cell_decoder.sv -----
// Top level of the run-length character-cell decoder.
//
//  channel   dir  payload (lowest bit first)
//  s_*       in   tdata: data_byte[7:0]; tuser: frame_start[0]
//  m_*       out  tdata: cell_char[7:0], cell_attr[15:8], cell_index[47:16];
//                 tlast: run_last; tuser: image_done[0]
//  cfg_*     in   cfg_wdata: total_cells[31:0], written when cfg_we is high
//
// One input word per cycle for header, char and attribute bytes while the output slot is
// free; at most one cell each. The closing byte of a repeat run closes the input while the
// run plays out one cell per cycle from the output register, when m_tready does not stall.
// Reset (aresetn low, synchronous) clears decode state and sets total_cells to 1.
// A stalled m_tready holds the output word and closes the input until it drains.
`default_nettype none
`include "assert_macros.svh"

module xbin_rle_cell_decoder (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [xrcd_pkg::BYTE_W-1:0]          s_tdata,   // data_byte
    input  wire logic [0:0]                           s_tuser,   // frame_start
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [xrcd_pkg::TDATA_W-1:0]              m_tdata,   // char, attr, index
    output logic                                      m_tlast,   // run_last
    output logic [0:0]                                m_tuser,   // image_done
    input  wire logic                                 cfg_we,
    input  wire logic [xrcd_pkg::COUNT_W-1:0]         cfg_wdata  // total_cells
);
    import xrcd_pkg::*;

    xrcd_cmd_t  cmd;
    xrcd_stat_t stat;

    xrcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    xrcd_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_byte        (s_tdata),
        .in_frame_start (s_tuser[0]),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .stat           (stat),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser)
    );

    // Checks
    `XRCD_ASSERT(a_take_xor_step, !(cmd.take && cmd.rep_emit), "byte taken during repeat step")
    `XRCD_ASSERT_SAME(a_done_is_last, m_tvalid && m_tuser[0], m_tlast, "image end not run end")
    `XRCD_ASSERT_NEXT(a_run_stalls, cmd.take && stat.rep_start, !s_tready, "input open in run")
    `XRCD_ASSERT_SAME(a_step_needs_slot, cmd.rep_emit, stat.slot_free, "step with full slot")

endmodule

`default_nettype wire
